[design/tfp_pkg.sv]
// Shared types, constants and helper functions of the tagged field packer.
`default_nettype none

package tfp_pkg;

   localparam int FrameBytes = 13;
   localparam int FrameBits  = FrameBytes * 8;
   localparam int CountBits  = 4;

   localparam logic [1:0] FUNC_UVARINT = 2'd0;
   localparam logic [1:0] FUNC_ZVARINT = 2'd1;
   localparam logic [1:0] FUNC_TAG2    = 2'd2;
   localparam logic [1:0] FUNC_TAG8    = 2'd3;

   localparam logic [1:0] TAG2_BITS2  = 2'd0;
   localparam logic [1:0] TAG2_BITS4  = 2'd1;
   localparam logic [1:0] TAG2_BITS6  = 2'd2;
   localparam logic [1:0] TAG2_BITS32 = 2'd3;

   localparam logic [1:0] TAG8_ZERO  = 2'd0;
   localparam logic [1:0] TAG8_BITS4 = 2'd1;
   localparam logic [1:0] TAG8_BITS8 = 2'd2;
   localparam logic [1:0] TAG8_BITS16 = 2'd3;

   // Cleanup of a selector pair: a 4-bit field only stays 4-bit if its
   // partner is 4-bit too, otherwise it widens to 8 bits.
   localparam logic [3:0] PAIR_FIX [16] = '{
      4'h0, 4'h2, 4'h2, 4'h3,
      4'h8, 4'h5, 4'hA, 4'hB,
      4'h8, 4'hA, 4'hA, 4'hB,
      4'hC, 4'hE, 4'hE, 4'hF
   };

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] value_a;
      logic signed [31:0] value_b;
      logic signed [31:0] value_c;
      logic signed [31:0] value_d;
   } req_type;

   typedef struct packed {
      logic [FrameBits-1:0] bytes;
      logic [CountBits-1:0] count;
   } frame_type;

   // True when v is representable as a signed number of the given width.
   function automatic logic fits(input logic signed [31:0] v, input int bits);
      logic signed [31:0] s;
      s = v >>> (bits - 1);
      return (s == 32'sd0) || (s == -32'sd1);
   endfunction

   // Keeps the low n bytes of a word.
   function automatic logic [31:0] byte_mask(input logic [2:0] n);
      logic [31:0] m;
      case (n)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'h0000_00FF;
         3'd2:    m = 32'h0000_FFFF;
         3'd3:    m = 32'h00FF_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

[design/tfp_if.sv]
// Handshake channel interfaces for requests and encoded bytes.
`default_nettype none

interface tfp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] value_a;
   logic signed [31:0] value_b;
   logic signed [31:0] value_c;
   logic signed [31:0] value_d;

   modport source (output valid, func, value_a, value_b, value_c, value_d, input ready);
   modport sink   (input valid, func, value_a, value_b, value_c, value_d, output ready);
endinterface

interface tfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

[design/tfp_encode.sv]
// Combinational encoder that turns one request into a byte frame and count.
`default_nettype none

module tfp_encode (
   input  tfp_pkg::req_type   req,
   output tfp_pkg::frame_type frame
);

   logic [31:0] ua, ub, uc, ud;
   logic [31:0] vint;
   logic [2:0]  vint_n;
   logic [39:0] vint_bytes;

   logic [1:0]  t2_mode;
   logic [1:0]  sz_a, sz_b, sz_c;
   logic [2:0]  na, nb, nc;
   logic [95:0] t2_payload;
   logic [23:0] t2_small;

   logic [1:0]  c8 [4];
   logic [3:0]  fix_lo, fix_hi;
   logic [7:0]  sel;
   logic [2:0]  n8 [4];
   logic [31:0] pair_a, pair_b;
   logic [2:0]  np_a, np_b;
   logic [63:0] t8_payload;

   always_comb begin
      ua = req.value_a;
      ub = req.value_b;
      uc = req.value_c;
      ud = req.value_d;

      // Varint: zigzag for the signed variant, then 7 bits per byte.
      if (req.func == tfp_pkg::FUNC_ZVARINT) begin
         vint = {ua[30:0], 1'b0} ^ {32{ua[31]}};
      end else begin
         vint = ua;
      end
      if (vint[31:28] != 4'd0) begin
         vint_n = 3'd5;
      end else if (vint[27:21] != 7'd0) begin
         vint_n = 3'd4;
      end else if (vint[20:14] != 7'd0) begin
         vint_n = 3'd3;
      end else if (vint[13:7] != 7'd0) begin
         vint_n = 3'd2;
      end else begin
         vint_n = 3'd1;
      end
      for (int k = 0; k < 4; k++) begin
         vint_bytes[8*k +: 8] = {(3'(k + 1) < vint_n), vint[7*k +: 7]};
      end
      vint_bytes[39:32] = {4'd0, vint[31:28]};

      // Tag2: the widest field picks the mode.
      if (!tfp_pkg::fits(req.value_a, 6) || !tfp_pkg::fits(req.value_b, 6) ||
          !tfp_pkg::fits(req.value_c, 6)) begin
         t2_mode = tfp_pkg::TAG2_BITS32;
      end else if (!tfp_pkg::fits(req.value_a, 4) || !tfp_pkg::fits(req.value_b, 4) ||
                   !tfp_pkg::fits(req.value_c, 4)) begin
         t2_mode = tfp_pkg::TAG2_BITS6;
      end else if (!tfp_pkg::fits(req.value_a, 2) || !tfp_pkg::fits(req.value_b, 2) ||
                   !tfp_pkg::fits(req.value_c, 2)) begin
         t2_mode = tfp_pkg::TAG2_BITS4;
      end else begin
         t2_mode = tfp_pkg::TAG2_BITS2;
      end

      sz_a = tfp_pkg::fits(req.value_a, 8)  ? 2'd0 :
             tfp_pkg::fits(req.value_a, 16) ? 2'd1 :
             tfp_pkg::fits(req.value_a, 24) ? 2'd2 : 2'd3;
      sz_b = tfp_pkg::fits(req.value_b, 8)  ? 2'd0 :
             tfp_pkg::fits(req.value_b, 16) ? 2'd1 :
             tfp_pkg::fits(req.value_b, 24) ? 2'd2 : 2'd3;
      sz_c = tfp_pkg::fits(req.value_c, 8)  ? 2'd0 :
             tfp_pkg::fits(req.value_c, 16) ? 2'd1 :
             tfp_pkg::fits(req.value_c, 24) ? 2'd2 : 2'd3;
      na = {1'b0, sz_a} + 3'd1;
      nb = {1'b0, sz_b} + 3'd1;
      nc = {1'b0, sz_c} + 3'd1;
      t2_payload = {64'd0, ua & tfp_pkg::byte_mask(na)}
                 | ({64'd0, ub & tfp_pkg::byte_mask(nb)} << {na, 3'b000})
                 | ({64'd0, uc & tfp_pkg::byte_mask(nc)} << {4'(na) + 4'(nb), 3'b000});

      case (t2_mode)
         tfp_pkg::TAG2_BITS2: t2_small = {16'd0, 2'b00, ua[1:0], ub[1:0], uc[1:0]};
         tfp_pkg::TAG2_BITS4: t2_small = {8'd0, ub[3:0], uc[3:0], 2'b01, 2'b00, ua[3:0]};
         tfp_pkg::TAG2_BITS6: t2_small = {uc[7:0], ub[7:0], 2'b10, ua[5:0]};
         default:             t2_small = 24'd0;
      endcase

      // Tag8: raw codes, pair cleanup, then per-pair payload bytes.
      c8[0] = (req.value_a == 32'sd0) ? tfp_pkg::TAG8_ZERO :
              tfp_pkg::fits(req.value_a, 4) ? tfp_pkg::TAG8_BITS4 :
              tfp_pkg::fits(req.value_a, 8) ? tfp_pkg::TAG8_BITS8 : tfp_pkg::TAG8_BITS16;
      c8[1] = (req.value_b == 32'sd0) ? tfp_pkg::TAG8_ZERO :
              tfp_pkg::fits(req.value_b, 4) ? tfp_pkg::TAG8_BITS4 :
              tfp_pkg::fits(req.value_b, 8) ? tfp_pkg::TAG8_BITS8 : tfp_pkg::TAG8_BITS16;
      c8[2] = (req.value_c == 32'sd0) ? tfp_pkg::TAG8_ZERO :
              tfp_pkg::fits(req.value_c, 4) ? tfp_pkg::TAG8_BITS4 :
              tfp_pkg::fits(req.value_c, 8) ? tfp_pkg::TAG8_BITS8 : tfp_pkg::TAG8_BITS16;
      c8[3] = (req.value_d == 32'sd0) ? tfp_pkg::TAG8_ZERO :
              tfp_pkg::fits(req.value_d, 4) ? tfp_pkg::TAG8_BITS4 :
              tfp_pkg::fits(req.value_d, 8) ? tfp_pkg::TAG8_BITS8 : tfp_pkg::TAG8_BITS16;
      fix_lo = tfp_pkg::PAIR_FIX[{c8[1], c8[0]}];
      fix_hi = tfp_pkg::PAIR_FIX[{c8[3], c8[2]}];
      sel = {fix_hi, fix_lo};
      for (int x = 0; x < 4; x++) begin
         case (sel[2*x +: 2])
            tfp_pkg::TAG8_BITS8:  n8[x] = 3'd1;
            tfp_pkg::TAG8_BITS16: n8[x] = 3'd2;
            default:              n8[x] = 3'd0;
         endcase
      end

      if (fix_lo[1:0] == tfp_pkg::TAG8_BITS4) begin
         pair_a = {24'd0, ub[3:0], ua[3:0]};
         np_a = 3'd1;
      end else begin
         pair_a = (ua & tfp_pkg::byte_mask(n8[0]))
                | ((ub & tfp_pkg::byte_mask(n8[1])) << {n8[0], 3'b000});
         np_a = n8[0] + n8[1];
      end
      if (fix_hi[1:0] == tfp_pkg::TAG8_BITS4) begin
         pair_b = {24'd0, ud[3:0], uc[3:0]};
         np_b = 3'd1;
      end else begin
         pair_b = (uc & tfp_pkg::byte_mask(n8[2]))
                | ((ud & tfp_pkg::byte_mask(n8[3])) << {n8[2], 3'b000});
         np_b = n8[2] + n8[3];
      end
      t8_payload = {32'd0, pair_a} | ({32'd0, pair_b} << {np_a, 3'b000});

      case (req.func)
         tfp_pkg::FUNC_UVARINT, tfp_pkg::FUNC_ZVARINT: begin
            frame.bytes = {64'd0, vint_bytes};
            frame.count = {1'b0, vint_n};
         end
         tfp_pkg::FUNC_TAG2: begin
            if (t2_mode == tfp_pkg::TAG2_BITS32) begin
               frame.bytes = {t2_payload, 2'b11, sz_c, sz_b, sz_a};
               frame.count = 4'd1 + 4'(na) + 4'(nb) + 4'(nc);
            end else begin
               frame.bytes = {80'd0, t2_small};
               case (t2_mode)
                  tfp_pkg::TAG2_BITS2: frame.count = 4'd1;
                  tfp_pkg::TAG2_BITS4: frame.count = 4'd2;
                  default:             frame.count = 4'd3;
               endcase
            end
         end
         default: begin
            frame.bytes = {32'd0, t8_payload, sel};
            frame.count = 4'd1 + 4'(np_a) + 4'(np_b);
         end
      endcase
   end

endmodule

`default_nettype wire

[design/tfp_serializer.sv]
// Frame register that hands out the encoded bytes one per item.
`default_nettype none

module tfp_serializer (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 load_valid,
   input  tfp_pkg::frame_type  frame,
   output logic                take,
   tfp_rsp_if.source           rsp
);

   logic [tfp_pkg::FrameBits-1:0] bytes_ff, bytes_in;
   logic [tfp_pkg::CountBits-1:0] left_ff, left_in;
   logic                          fire;

   assign rsp.valid    = (left_ff != '0);
   assign rsp.out_byte = bytes_ff[7:0];
   assign rsp.last     = (left_ff == tfp_pkg::CountBits'(1));
   assign fire         = rsp.valid && rsp.ready;
   // A new frame can enter when empty or when the final byte leaves now.
   assign take         = !rsp.valid || (fire && rsp.last);

   always_comb begin
      bytes_in = bytes_ff;
      left_in  = left_ff;
      if (load_valid && take) begin
         bytes_in = frame.bytes;
         left_in  = frame.count;
      end else if (fire) begin
         bytes_in = bytes_ff >> 8;
         left_in  = left_ff - tfp_pkg::CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
      bytes_ff <= bytes_in;
   end

endmodule

`default_nettype wire

[design/tagged_field_packer.sv]
// Top level of the tagged field packer: request register, encoder, byte serializer.
//
// Usage: a request (func and up to four signed values) enters on req_chan with
// a valid/ready handshake. The block answers with 1 to 13 items on rsp_chan,
// one encoded byte each, and raises last on the final byte of the request.
// Path: an accepted request is held in the request register, and its encoded
// frame then loads into the frame register, from which the first byte is
// presented.
// Throughput: the output delivers one byte per cycle while rsp_chan.ready
// is high; the next frame loads in the same cycle the previous last byte
// is taken, with no gap. One request waits in the request register while a
// frame drains, so req_chan.ready stays high until that register is full
// and the frame register is busy.
// Reset: synchronous and active high; it empties the request register and the
// frame register, and items that were in flight are dropped.
// Stall: when the receiver holds rsp_chan.ready low, the current byte holds
// steady, then the request register fills and req_chan.ready falls.
`default_nettype none

module tagged_field_packer (
   input  wire       clock,
   input  wire       reset,
   tfp_req_if.sink   req_chan,
   tfp_rsp_if.source rsp_chan
);

   logic               in_valid_ff, in_valid_in;
   tfp_pkg::req_type   in_data_ff, in_data_in;
   tfp_pkg::frame_type frame;
   logic               take;
   logic               req_fire;

   // The request register frees up whenever its item moves into the
   // serializer, so a new item can be taken in that same cycle.
   assign req_chan.ready = !in_valid_ff || take;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = req_fire || (in_valid_ff && !take);
      in_data_in  = in_data_ff;
      if (req_fire) begin
         in_data_in.func    = req_chan.func;
         in_data_in.value_a = req_chan.value_a;
         in_data_in.value_b = req_chan.value_b;
         in_data_in.value_c = req_chan.value_c;
         in_data_in.value_d = req_chan.value_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
   end

   // All encoding happens in one combinational pass from the request register.
   tfp_encode u_encode (
      .req   (in_data_ff),
      .frame (frame)
   );

   tfp_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .frame      (frame),
      .take       (take),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire

[test/tfp_byte_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the tagged field packer: predicts each request's byte stream and checks it.

module tfp_byte_checker (
   input  logic clock,
   input  logic reset,
   tfp_req_if   req_mon,
   tfp_rsp_if   rsp_mon,
   output int   mismatches,
   output int   bytes_owed
);
   import tfp_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } coded_byte_type;

   coded_byte_type owed_bytes [$];
   int             fail_count = 0;
   int             owed_count = 0;

   assign mismatches = fail_count;
   assign bytes_owed = owed_count;

   // A 4-bit code survives only when its pair partner is 4-bit as well.
   function automatic logic [3:0] widen_lone_nibble(input logic [3:0] pair);
      logic [1:0] lo;
      logic [1:0] hi;
      lo = pair[1:0];
      hi = pair[3:2];
      if (lo == TAG8_BITS4 && hi != TAG8_BITS4) return {hi, TAG8_BITS8};
      if (hi == TAG8_BITS4 && lo != TAG8_BITS4) return {TAG8_BITS8, lo};
      return pair;
   endfunction

   // Appends the bytes that one request encodes to, last flag on the final one.
   function automatic void predict_bytes(input logic [1:0] op,
                                         input logic signed [31:0] a, b, c, d);
      logic signed [31:0] vals [4];
      logic [7:0]         frame [$];
      logic [31:0]        word;
      logic [1:0]         mode;
      logic [1:0]         code;
      logic [5:0]         sizes;
      logic [7:0]         sel;
      int                 x;
      int                 k;
      vals[0] = a;
      vals[1] = b;
      vals[2] = c;
      vals[3] = d;
      case (op)
         FUNC_UVARINT, FUNC_ZVARINT: begin
            word = (op == FUNC_UVARINT) ? a : ({a[30:0], 1'b0} ^ {32{a[31]}});
            while (word > 127) begin
               frame.push_back({1'b1, word[6:0]});
               word = word >> 7;
            end
            frame.push_back(word[7:0]);
         end
         FUNC_TAG2: begin
            mode = TAG2_BITS2;
            for (x = 0; x < 3; x++) begin
               if (vals[x] >= 32 || vals[x] < -32)
                  mode = TAG2_BITS32;
               else if ((vals[x] >= 8 || vals[x] < -8) && mode < TAG2_BITS6)
                  mode = TAG2_BITS6;
               else if ((vals[x] >= 2 || vals[x] < -2) && mode < TAG2_BITS4)
                  mode = TAG2_BITS4;
            end
            case (mode)
               TAG2_BITS2: frame.push_back({TAG2_BITS2, a[1:0], b[1:0], c[1:0]});
               TAG2_BITS4: begin
                  frame.push_back({TAG2_BITS4, 2'b00, a[3:0]});
                  frame.push_back({b[3:0], c[3:0]});
               end
               TAG2_BITS6: begin
                  frame.push_back({TAG2_BITS6, a[5:0]});
                  frame.push_back(b[7:0]);
                  frame.push_back(c[7:0]);
               end
               default: begin
                  for (x = 0; x < 3; x++) begin
                     if (vals[x] >= -128 && vals[x] < 128)           sizes[2*x +: 2] = 2'd0;
                     else if (vals[x] >= -32768 && vals[x] < 32768)   sizes[2*x +: 2] = 2'd1;
                     else if (vals[x] >= -8388608 && vals[x] < 8388608)
                        sizes[2*x +: 2] = 2'd2;
                     else                                             sizes[2*x +: 2] = 2'd3;
                  end
                  frame.push_back({TAG2_BITS32, sizes});
                  for (x = 0; x < 3; x++) begin
                     for (k = 0; k <= int'(sizes[2*x +: 2]); k++) begin
                        word = vals[x] >> (8 * k);
                        frame.push_back(word[7:0]);
                     end
                  end
               end
            endcase
         end
         default: begin
            for (x = 0; x < 4; x++) begin
               if (vals[x] == 0)                        code = TAG8_ZERO;
               else if (vals[x] >= -8 && vals[x] <= 7)     code = TAG8_BITS4;
               else if (vals[x] >= -128 && vals[x] <= 127) code = TAG8_BITS8;
               else                                     code = TAG8_BITS16;
               sel[2*x +: 2] = code;
            end
            sel = {widen_lone_nibble(sel[7:4]), widen_lone_nibble(sel[3:0])};
            frame.push_back(sel);
            x = 0;
            while (x < 4) begin
               code = sel[2*x +: 2];
               case (code)
                  TAG8_BITS4: begin
                     frame.push_back({vals[x+1][3:0], vals[x][3:0]});
                     x += 2;
                  end
                  TAG8_BITS8: begin
                     frame.push_back(vals[x][7:0]);
                     x++;
                  end
                  TAG8_BITS16: begin
                     frame.push_back(vals[x][7:0]);
                     frame.push_back(vals[x][15:8]);
                     x++;
                  end
                  default: x++;
               endcase
            end
         end
      endcase
      for (x = 0; x < frame.size(); x++)
         owed_bytes.push_back('{data: frame[x], last: (x == frame.size() - 1)});
   endfunction

   always @(posedge clock) begin
      coded_byte_type due;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            predict_bytes(req_mon.func, req_mon.value_a, req_mon.value_b,
                          req_mon.value_c, req_mon.value_d);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_bytes.size() == 0) begin
               $display("%0t: byte %02h last %0b arrived with nothing expected",
                        $time, rsp_mon.out_byte, rsp_mon.last);
               fail_count++;
            end else begin
               due = owed_bytes.pop_front();
               if (rsp_mon.out_byte !== due.data) begin
                  $display("%0t: out_byte expected %02h, got %02h",
                           $time, due.data, rsp_mon.out_byte);
                  fail_count++;
               end
               if (rsp_mon.last !== due.last) begin
                  $display("%0t: last expected %0b, got %0b", $time, due.last, rsp_mon.last);
                  fail_count++;
               end
            end
         end
         owed_count = owed_bytes.size();
      end
   end

endmodule

[test/tagged_field_packer_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the tagged field packer: stimulus, receiver stalls and the verdict.

module tagged_field_packer_tb;
   import tfp_pkg::*;

   // Run shape. The cycle limit is several times the slowest legal run:
   // every item at 13 bytes, each byte behind the longest receiver stall,
   // plus the longest sender gaps and the single long hold-off.
   localparam int RandomRequests = 136;
   localparam int CycleLimit     = 500_000;
   localparam int LongHold       = 150;
   localparam int HoldAfter      = 60;
   localparam int DrainCycles    = 16;

   logic clock;
   logic reset;
   int   cycle_count   = 0;
   int   requests_sent = 0;
   int   mismatches;
   int   bytes_owed;

   tfp_req_if req_chan ();
   tfp_rsp_if rsp_chan ();

   tagged_field_packer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The scoreboard watches both channels and reports how many bytes are
   // still owed and how many compares went wrong.
   tfp_byte_checker byte_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .mismatches (mismatches),
      .bytes_owed (bytes_owed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost byte ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Random value of a random signed width, so that every size class of both
   // packing schemes shows up often, along with exact zeros and full words.
   function automatic logic signed [31:0] random_value();
      int          width;
      logic [31:0] raw;
      case ($urandom_range(0, 5))
         0:       width = 0;
         1, 2:    width = $urandom_range(1, 9);
         3:       width = $urandom_range(10, 17);
         4:       width = $urandom_range(18, 25);
         default: width = $urandom_range(26, 32);
      endcase
      if (width == 0) return 32'sd0;
      raw = $urandom;
      return $signed(raw << (32 - width)) >>> (32 - width);
   endfunction

   // Idle gap before an item: usually none, sometimes short, rarely long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one request and returns at the edge where it is taken. Ready is
   // sampled at the falling edge, where nothing is changing, so the decision
   // does not depend on event order at the rising edge. With no gap, valid
   // simply stays high and only the payload changes.
   task automatic offer_request(input logic [1:0] op, input logic signed [31:0] a, b, c, d,
                                input int gap);
      bit taken;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.func    <= op;
      req_chan.value_a <= a;
      req_chan.value_b <= b;
      req_chan.value_c <= c;
      req_chan.value_d <= d;
      req_chan.valid   <= 1'b1;
      do begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end while (!taken);
      requests_sent++;
   endtask

   // Receiver. It mostly accepts, stalls in short and occasional long bursts,
   // has a recurring steady window, and once holds off for a long stretch
   // while the sender keeps pushing, so that both internal registers fill
   // and the request channel has to stall.
   initial begin
      int stall_left;
      int roll;
      bit held;
      stall_left = 0;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      repeat (2) @(posedge clock);
      forever begin
         if (!held && requests_sent >= HoldAfter) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
         end else begin
            if (stall_left > 0) begin
               rsp_chan.ready <= 1'b0;
               stall_left--;
            end else if ((cycle_count % 600) < 150) begin
               rsp_chan.ready <= 1'b1;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 70) begin
                  rsp_chan.ready <= 1'b1;
               end else begin
                  rsp_chan.ready <= 1'b0;
                  stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
               end
            end
            @(posedge clock);
         end
      end
   end

   // Stimulus: reset, a directed set, then random requests, then the drain.
   initial begin
      int idx;
      int gap;
      req_chan.valid   <= 1'b0;
      req_chan.func    <= FUNC_UVARINT;
      req_chan.value_a <= 32'sd0;
      req_chan.value_b <= 32'sd0;
      req_chan.value_c <= 32'sd0;
      req_chan.value_d <= 32'sd0;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Unsigned varints: the one-byte limit, the first two-byte value and
      // the full 32-bit word, which takes five bytes.
      offer_request(FUNC_UVARINT, 32'sd0, 0, 0, 0, 0);
      offer_request(FUNC_UVARINT, 32'sd127, 0, 0, 0, 0);
      offer_request(FUNC_UVARINT, 32'sd128, 0, 0, 0, pick_gap());
      offer_request(FUNC_UVARINT, 32'shFFFF_FFFF, 0, 0, 0, 0);

      // Zigzag varints around zero, at the one-byte edge and at both ends of
      // the signed range.
      offer_request(FUNC_ZVARINT, 32'sd0, 0, 0, 0, 0);
      offer_request(FUNC_ZVARINT, -32'sd1, 0, 0, 0, 0);
      offer_request(FUNC_ZVARINT, -32'sd64, 0, 0, 0, pick_gap());
      offer_request(FUNC_ZVARINT, 32'sd64, 0, 0, 0, 0);
      offer_request(FUNC_ZVARINT, 32'sh8000_0000, 0, 0, 0, 0);
      offer_request(FUNC_ZVARINT, 32'sh7FFF_FFFF, 0, 0, 0, pick_gap());

      // Tag2 in each mode, including the 6-bit mode where b and c go out as
      // whole bytes with their sign copies, and the longest 32-bit frame.
      offer_request(FUNC_TAG2, 32'sd0, 32'sd0, 32'sd0, 32'sd5, 0);
      offer_request(FUNC_TAG2, -32'sd2, 32'sd1, -32'sd1, 0, 0);
      offer_request(FUNC_TAG2, -32'sd8, 32'sd7, 32'sd2, 0, pick_gap());
      offer_request(FUNC_TAG2, -32'sd32, 32'sd31, -32'sd9, 0, 0);
      offer_request(FUNC_TAG2, 32'sd127, -32'sd129, 32'sd8388607, 0, 0);
      offer_request(FUNC_TAG2, 32'sh8000_0000, 32'sd32767, -32'sd8388609, 0, 0);
      offer_request(FUNC_TAG2, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd8388609, 0, pick_gap());

      // Tag8: all zero, a lone 4-bit field that must widen, two 4-bit pairs,
      // the 8-bit limits, and 16-bit fields whose values are cut to 16 bits.
      offer_request(FUNC_TAG8, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 0);
      offer_request(FUNC_TAG8, 32'sd5, 32'sd0, -32'sd8, 32'sd200, 0);
      offer_request(FUNC_TAG8, -32'sd8, 32'sd7, -32'sd1, 32'sd1, 0);
      offer_request(FUNC_TAG8, -32'sd128, 32'sd127, 32'sd8, -32'sd9, pick_gap());
      offer_request(FUNC_TAG8, 32'sd70000, -32'sd40000, 32'sd32767, -32'sd32768, 0);
      offer_request(FUNC_TAG8, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, 32'sd0, 0);

      // Random requests. A middle stretch runs with no sender gaps at all.
      for (idx = 0; idx < RandomRequests; idx++) begin
         gap = (idx >= 70 && idx < 110) ? 0 : pick_gap();
         offer_request(2'($urandom_range(0, 3)), random_value(), random_value(),
                       random_value(), random_value(), gap);
      end
      req_chan.valid <= 1'b0;

      // Wait for every predicted byte, then a further drain period so that a stray
      // extra byte would still be caught.
      @(negedge clock);
      while (bytes_owed != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
